/* hdl/fpfl_pkg.sv */
// ----------------------------------------------------------------------------
// Pool allocator package
// Shared widths, operation and status codes, and the word types passed
// between the channel stage and the allocator core.
// ----------------------------------------------------------------------------
package fpfl_pkg;

  localparam int POOL_SIZE = 256;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;

  // Largest pool a reset can build: indices are IDX_W bits wide
  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int POOL_CAP  = (POOL_SIZE < IDX_SPAN) ? POOL_SIZE : IDX_SPAN;
  localparam logic [CNT_W-1:0] POOL_CAP_C  = CNT_W'(POOL_CAP);
  localparam logic [CNT_W-1:0] CNT_RESET_C = CNT_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_RESET = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  granted_index;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  active_count;
    logic [CNT_W-1:0]  free_count;
  } result_t;

endpackage

/* hdl/fpfl_in_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate, free or pool reset word.
// ----------------------------------------------------------------------------
interface fpfl_in_if import fpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, kind, entry_index, input ready);
  modport sink   (input valid, kind, entry_index, output ready);
endinterface

/* hdl/fpfl_out_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface fpfl_out_if import fpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  granted_index;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, granted_index, status, active_count, free_count,
                  input ready);
  modport sink   (input valid, granted_index, status, active_count, free_count,
                  output ready);
endinterface

/* hdl/fpfl_core.sv */
// ----------------------------------------------------------------------------
// Pool allocator core
// Holds the free list (link memory, head, prefetched head link), the
// never-used watermark and the in-use bits; executes one word per fire.
// ----------------------------------------------------------------------------
module fpfl_core import fpfl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  item_t               item,
  input  logic [CNT_W-1:0]    entry_count,
  output result_t             res
);

  // Link memory: written on every push, so no unwritten link is followed
  logic [IDX_W-1:0] link_mem [POOL_SIZE];

  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     head_link_r;
  logic                 nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]     wm_r, wm_nxt;
  logic [CNT_W-1:0]     active_r, active_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [POOL_SIZE-1:0] in_use_r, in_use_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [IDX_W-1:0]     grant;
  status_t              status;

  // Execute the word against the current state
  always_comb begin
    head_nxt   = head_r;
    wm_nxt     = wm_r;
    active_nxt = active_r;
    limit_nxt  = limit_r;
    in_use_nxt = in_use_r;
    mem_we     = 1'b0;
    mem_waddr  = item.entry_index;
    mem_wdata  = nonempty_r ? head_r : '0;
    grant      = '0;
    status     = ST_OK;
    unique case (item.kind)
      KIND_ALLOC: begin
        priority if (nonempty_r) begin
          grant            = head_r;
          head_nxt         = head_link_r;
          in_use_nxt[grant] = 1'b1;
          active_nxt       = CNT_W'(active_r + 1'b1);
        end else if (wm_r < limit_r) begin
          grant            = wm_r[IDX_W-1:0];
          wm_nxt           = CNT_W'(wm_r + 1'b1);
          in_use_nxt[grant] = 1'b1;
          active_nxt       = CNT_W'(active_r + 1'b1);
        end else begin
          status = ST_EMPTY;
        end
      end
      KIND_FREE: begin
        priority if ({1'b0, item.entry_index} >= limit_r) begin
          status = ST_RANGE;
        end else if (!in_use_r[item.entry_index]) begin
          status = ST_DOUBLE;
        end else begin
          mem_we                       = 1'b1;
          head_nxt                     = item.entry_index;
          in_use_nxt[item.entry_index] = 1'b0;
          active_nxt                   = CNT_W'(active_r - 1'b1);
        end
      end
      KIND_RESET: begin
        head_nxt   = '0;
        wm_nxt     = '0;
        active_nxt = '0;
        in_use_nxt = '0;
        limit_nxt  = (entry_count > POOL_CAP_C) ? POOL_CAP_C : entry_count;
      end
      default: begin
        // unused code: no change
      end
    endcase
    nonempty_nxt = wm_nxt > active_nxt;
    mem_raddr    = fire ? head_nxt : head_r;
  end

  // Result word
  always_comb begin
    res.granted_index = grant;
    res.status        = status;
    res.active_count  = active_nxt;
    res.free_count    = CNT_W'(limit_nxt - active_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      nonempty_r <= 1'b0;
      wm_r       <= '0;
      active_r   <= '0;
      limit_r    <= '0;
      in_use_r   <= '0;
    end else if (fire) begin
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      wm_r       <= wm_nxt;
      active_r   <= active_nxt;
      limit_r    <= limit_nxt;
      in_use_r   <= in_use_nxt;
    end
  end

  // Link memory write, and prefetch of the link behind the next head
  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (fire && mem_we && (mem_waddr == mem_raddr)) begin
      head_link_r <= mem_wdata;
    end else begin
      head_link_r <= link_mem[mem_raddr];
    end
  end

`ifndef SYNTH
  a_active_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= limit_r)
    else $error("active count exceeds pool size");

  a_wm_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (wm_r <= limit_r) && (active_r <= wm_r))
    else $error("watermark out of order with active count or pool size");

  a_nonempty_track: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r == (wm_r > active_r))
    else $error("free list flag disagrees with counts");

  a_grant_marks_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.kind == KIND_ALLOC) && (status == ST_OK)
    |=> in_use_r[$past(grant)])
    else $error("granted entry not marked in use");
`endif

endmodule

/* hdl/fixed_pool_free_list_allocator.sv */
// Path: accepted words pass the request register, core and response register in order.
// Throughput: one request word per cycle; a waiting response stalls the core, and the
// request register then takes at most one more word. The link prefetch register feeds
// back-to-back pops.
// Reset: synchronous active-low rst_n empties the pool (size 0 until a pool
// reset request) and sets the entry count register to 256; no clearing pass.
// ----------------------------------------------------------------------------
// Fixed pool free list allocator
// Request register, allocator core and response register with valid/ready
// channels and a single entry count configuration register.
// ----------------------------------------------------------------------------
module fixed_pool_free_list_allocator import fpfl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  fpfl_in_if.sink          in_ch,
  fpfl_out_if.source       out_ch
);

  logic [CNT_W-1:0] entry_count_r;
  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             out_valid_r;
  result_t          out_word_r;
  result_t          res;
  logic             adv;
  logic             fire;
  logic             in_acc;

  assign adv         = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CNT_RESET_C;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.kind        <= in_ch.kind;
      s1_item_r.entry_index <= in_ch.entry_index;
    end
  end

  fpfl_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_item_r),
    .entry_count (entry_count_r),
    .res         (res)
  );

  // Response register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted_index = out_word_r.granted_index;
  assign out_ch.status        = out_word_r.status;
  assign out_ch.active_count  = out_word_r.active_count;
  assign out_ch.free_count    = out_word_r.free_count;

endmodule
